[hdl/bct_pkg.sv]
// Shared types and constants of the B-spline curve tessellator.
package bct_pkg;

  // Default sizes
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 32;

  // Number formats: parameter Q12.20, basis Q1.30
  localparam int unsigned PFrac    = 20;
  localparam int unsigned BFrac    = 30;
  localparam int unsigned SnapUlps = 5;
  localparam logic [30:0] BasisOne = 31'h4000_0000;
  // floor(v * RecipThree / 2^33) == floor(v / 3) for any 32-bit v
  localparam logic [31:0] RecipThree = 32'hAAAA_AAAB;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CfgDegree   = 2'd0;
  localparam logic [1:0] CfgClosed   = 2'd1;
  localparam logic [1:0] CfgSegments = 2'd2;

  // Request word
  typedef struct packed {
    op_e                op;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
  } req_word_t;

  // Sample word
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last_sample;
    logic               too_few_points;
  } smp_word_t;

endpackage

[hdl/bct_chan_if.sv]
// Valid/ready channel carrying one word of a given type.
interface bct_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/bct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bct_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/bspline_curve_tessellator.sv]
// Top level: uniform B-spline curve tessellator on one shared multiplier.
//
//  channel   dir  word          handshake
//  req_i     in   req_word_t    valid/ready, op clear/append/sample
//  smp_o     out  smp_word_t    valid/ready, one word per sample request
//  cfg_*     in   index, data   write enable, no back-pressure
//
// Clear, append and unused ops are handled in idle. A sample runs each
// de Boor term (2, 5 or 9 terms for degree 1, 2, 3) through DMUL, DDIV, EMUL
// and EDIV, then each of the degree + 1 control points through RD, MX, MY and
// AY, besides accept, setup and hand-over; a sample snapped to the end knot
// skips the terms. The first sample of a walk adds the bit-serial step divide
// of clog2(MAX_POINTS+1)+20 quotient bits. The single multiplier sets the pace.
// rst_ni clears the control registers asynchronously; no store clearing pass is needed.
// A finished sample waits in the output register while requests are taken;
// a new sample waits in hand-over for the register to empty, and the request
// side is not ready meanwhile.
module bspline_curve_tessellator #(
  parameter int unsigned MAX_POINTS = bct_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = bct_pkg::CoordBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bct_chan_if.sink   req_i,
  bct_chan_if.source smp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [5:0] cfg_data_i
);

  localparam int unsigned AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned PC_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW   = $clog2(MAX_POINTS + 8);
  localparam int unsigned P1W  = $clog2(32 * (MAX_POINTS + 3) + 1);
  localparam int unsigned NW   = PC_W + bct_pkg::PFrac;
  localparam int unsigned DCW  = $clog2(NW + 1);
  localparam logic signed [35:0] SatHi = (COORD_BITS >= 32) ? 36'sd2147483647
                                       : ((36'sd1 <<< (COORD_BITS - 1)) - 36'sd1);
  localparam logic signed [35:0] SatLo = -SatHi - 36'sd1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0_0000_0000_0001,
    S_DIV   = 13'b0_0000_0000_0010,
    S_SETUP = 13'b0_0000_0000_0100,
    S_DMUL  = 13'b0_0000_0000_1000,
    S_DDIV  = 13'b0_0000_0001_0000,
    S_EMUL  = 13'b0_0000_0010_0000,
    S_EDIV  = 13'b0_0000_0100_0000,
    S_RD    = 13'b0_0000_1000_0000,
    S_MX    = 13'b0_0001_0000_0000,
    S_MY    = 13'b0_0010_0000_0000,
    S_AY    = 13'b0_0100_0000_0000,
    S_OUT   = 13'b0_1000_0000_0000,
    S_SPARE = 13'b1_0000_0000_0000
  } state_e;

  // Knot value at index idx (integer knots)
  function automatic logic [IW-1:0] knot_at(input logic [IW-1:0] idx,
                                            input logic [IW-1:0] np,
                                            input logic [2:0]    kk,
                                            input logic          cl);
    logic [IW-1:0] kw;
    kw = IW'(kk);
    if (cl) return idx - IW'(1);
    if (idx <= kw) return '0;
    if (idx <= np + IW'(1)) return idx - kw;
    return np + IW'(1) - kw;
  endfunction

  // Quotient by a knot span of 1, 2 or 3
  function automatic logic [31:0] span_div(input logic [1:0]  m,
                                           input logic [31:0] v,
                                           input logic [31:0] p3);
    case (m)
      2'd3:    return p3;
      2'd2:    return v >> 1;
      default: return v;
    endcase
  endfunction

  // Q24.42 sum to Q20.12, truncated toward zero and saturated
  function automatic logic [31:0] sat_coord(input logic signed [65:0] acc);
    logic signed [65:0] bias;
    logic signed [35:0] q;
    bias = acc + ((acc < 0) ? 66'sd1073741823 : 66'sd0);
    q    = bias[65:30];
    if (q > SatHi) return SatHi[31:0];
    if (q < SatLo) return SatLo[31:0];
    return q[31:0];
  endfunction

  // Registers
  state_e             state_q, state_d;
  logic [1:0]         deg_q, deg_d;
  logic               closed_q, closed_d;
  logic [5:0]         spp_q, spp_d;
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [P1W-1:0]     cnt_q, cnt_d;
  logic [31:0]        accum_q, accum_d;
  logic [31:0]        step_q, step_d;
  logic               out_valid_q, out_valid_d;
  bct_pkg::smp_word_t out_word_q, out_word_d;
  logic [1:0]         dege_q, dege_d;
  logic [IW-1:0]      npts_q, npts_d;
  logic [P1W-1:0]     p1_q, p1_d;
  logic [31:0]        t_q, t_d;
  logic               last_q, last_d;
  logic               few_q, few_d;
  logic [IW-1:0]      b0_q, b0_d;
  logic [2:0]         ord_q, ord_d;
  logic [1:0]         s_q, s_d;
  logic [30:0]        l_q [4];
  logic [30:0]        l_d [4];
  logic signed [66:0] prod_q, prod_d;
  logic [31:0]        d_q, d_d;
  logic signed [65:0] accx_q, accx_d;
  logic signed [65:0] accy_q, accy_d;
  logic [P1W-1:0]     rem_q, rem_d;
  logic [NW-1:0]      quo_q, quo_d;
  logic [P1W-1:0]     dvs_q, dvs_d;
  logic [DCW-1:0]     dcnt_q, dcnt_d;

  // Shared multiplier
  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // Control point stores
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   rd_x;
  logic [31:0]   rd_y;

  assign ram_waddr = pc_q[AW-1:0];

  bct_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.data.in_x),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_x)
  );

  bct_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.data.in_y),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_y)
  );

  // Request decode helpers
  logic [1:0]      deg_e;
  logic [2:0]      k_e;
  logic            few_e;
  logic [IW-1:0]   npts_e;
  logic [5:0]      spp_e;
  logic [P1W-1:0]  p1_e;

  always_comb begin
    deg_e  = (deg_q == 2'd0) ? 2'd1 : deg_q;
    k_e    = {1'b0, deg_e} + 3'd1;
    few_e  = IW'(pc_q) < IW'(k_e);
    npts_e = IW'(pc_q) + (closed_q ? IW'(deg_e) : '0);
    if (spp_q == 6'd0) begin
      spp_e = 6'd1;
    end else if (spp_q > 6'd32) begin
      spp_e = 6'd32;
    end else begin
      spp_e = spp_q;
    end
    p1_e = P1W'(spp_e) * P1W'(npts_e);
  end

  // Per-sample helpers
  logic [2:0]    k_q;
  logic [IW-1:0] nplusc;
  logic [31:0]   tend;
  logic          last_e;
  logic          snap;
  logic [IW-1:0] jidx;
  logic [IW-1:0] ci;
  logic [IW-1:0] xi, xa, xb, xc, md, me;
  logic [32:0]   num_d, num_e;
  logic [2:0]    lsel;
  logic [30:0]   lrd;
  logic [31:0]   v;
  logic [31:0]   term;
  logic [32:0]   bsum;
  logic [IW-1:0] im1, sidx;
  logic [P1W:0]  rem_sh, rem_sub;
  logic          rem_ge;

  always_comb begin
    k_q    = {1'b0, dege_q} + 3'd1;
    nplusc = npts_q + IW'(k_q);
    tend   = 32'({knot_at(nplusc, npts_q, k_q, closed_q), {bct_pkg::PFrac{1'b0}}});
    last_e = cnt_q >= (p1_q - P1W'(1));
    snap   = (accum_q >= tend) || ((tend - accum_q) <= 32'(bct_pkg::SnapUlps)) ||
             (!closed_q && last_e);
    jidx   = IW'(accum_q[31:bct_pkg::PFrac]) + (closed_q ? IW'(1) : IW'(k_q));
    // knots around the current term
    ci    = b0_q + IW'(s_q);
    xi    = knot_at(ci, npts_q, k_q, closed_q);
    xa    = knot_at(ci + IW'(ord_q) - IW'(1), npts_q, k_q, closed_q);
    xb    = knot_at(ci + IW'(1), npts_q, k_q, closed_q);
    xc    = knot_at(ci + IW'(ord_q), npts_q, k_q, closed_q);
    md    = xa - xi;
    me    = xc - xb;
    num_d = 33'(t_q) - 33'({xi, {bct_pkg::PFrac{1'b0}}});
    num_e = 33'({xc, {bct_pkg::PFrac{1'b0}}}) - 33'(t_q);
    // basis window read
    lsel = (state_q == S_EMUL) ? ({1'b0, s_q} + 3'd1) : {1'b0, s_q};
    lrd  = lsel[2] ? '0 : l_q[lsel[1:0]];
    // span division of the last product; second term only over a non-empty span
    v    = prod_q[51:20];
    term = span_div((state_q == S_EDIV) ? me[1:0] : md[1:0], v, mul_p[64:33]);
    bsum = {1'b0, d_q} + ((xc > xb) ? {1'b0, term} : 33'd0);
    // control point index, wrapping for closed curves
    im1  = ci - IW'(1);
    sidx = (im1 >= IW'(pc_q)) ? (im1 - IW'(pc_q)) : im1;
    // step divide
    rem_sh  = {rem_q, quo_q[NW-1]};
    rem_ge  = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  assign ram_raddr   = sidx[AW-1:0];
  assign req_i.ready = (state_q == S_IDLE);
  assign smp_o.valid = out_valid_q;
  assign smp_o.data  = out_word_q;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    deg_d       = deg_q;
    closed_d    = closed_q;
    spp_d       = spp_q;
    pc_d        = pc_q;
    cnt_d       = cnt_q;
    accum_d     = accum_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !smp_o.ready;
    out_word_d  = out_word_q;
    dege_d      = dege_q;
    npts_d      = npts_q;
    p1_d        = p1_q;
    t_d         = t_q;
    last_d      = last_q;
    few_d       = few_q;
    b0_d        = b0_q;
    ord_d       = ord_q;
    s_d         = s_q;
    l_d         = l_q;
    prod_d      = prod_q;
    d_d         = d_q;
    accx_d      = accx_q;
    accy_d      = accy_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    dcnt_d      = dcnt_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          case (req_i.data.op)
            bct_pkg::OP_CLEAR: begin
              pc_d    = '0;
              cnt_d   = '0;
              accum_d = '0;
              step_d  = '0;
            end
            bct_pkg::OP_APPEND: begin
              if (pc_q < PC_W'(MAX_POINTS)) begin
                ram_we = 1'b1;
                pc_d   = pc_q + PC_W'(1);
              end
              cnt_d   = '0;
              accum_d = '0;
              step_d  = '0;
            end
            bct_pkg::OP_SAMPLE: begin
              dege_d = deg_e;
              npts_d = npts_e;
              p1_d   = p1_e;
              few_d  = few_e;
              last_d = 1'b0;
              accx_d = '0;
              accy_d = '0;
              if (few_e) begin
                state_d = S_OUT;
              end else if (cnt_q == '0) begin
                // walk start: first parameter and step divide
                accum_d = closed_q ? 32'({deg_e, {bct_pkg::PFrac{1'b0}}}) : '0;
                quo_d   = closed_q ? {pc_q, {bct_pkg::PFrac{1'b0}}}
                                   : {pc_q - PC_W'(deg_e), {bct_pkg::PFrac{1'b0}}};
                dvs_d   = p1_e - P1W'(1);
                rem_d   = '0;
                dcnt_d  = DCW'(NW);
                state_d = S_DIV;
              end else begin
                state_d = S_SETUP;
              end
            end
            default: ;
          endcase
        end
      end

      // one quotient bit a cycle
      S_DIV: begin
        rem_d  = rem_ge ? rem_sub[P1W-1:0] : rem_sh[P1W-1:0];
        quo_d  = {quo_q[NW-2:0], rem_ge};
        dcnt_d = dcnt_q - DCW'(1);
        if (dcnt_q == DCW'(1)) begin
          step_d  = 32'({quo_q[NW-2:0], rem_ge});
          state_d = S_SETUP;
        end
      end

      // snap the parameter, seed the basis window
      S_SETUP: begin
        t_d    = snap ? tend : accum_q;
        last_d = last_e;
        for (int n = 0; n < 4; n++) begin
          l_d[n] = '0;
        end
        l_d[dege_q] = bct_pkg::BasisOne;
        if (snap) begin
          b0_d    = npts_q - IW'(dege_q);
          s_d     = 2'd0;
          state_d = S_RD;
        end else begin
          b0_d    = jidx - IW'(dege_q);
          ord_d   = 3'd2;
          s_d     = dege_q - 2'd1;
          state_d = S_DMUL;
        end
      end

      S_DMUL: begin
        mul_a   = $signed(num_d);
        mul_b   = $signed({3'b000, lrd});
        prod_d  = mul_p;
        state_d = S_DDIV;
      end

      S_DDIV: begin
        mul_a   = $signed({1'b0, v});
        mul_b   = $signed({2'b00, bct_pkg::RecipThree});
        d_d     = (xa > xi) ? term : '0;
        state_d = S_EMUL;
      end

      S_EMUL: begin
        mul_a   = $signed(num_e);
        mul_b   = $signed({3'b000, lrd});
        prod_d  = mul_p;
        state_d = S_EDIV;
      end

      // second term, clamp, write back and step the triangle
      S_EDIV: begin
        mul_a = $signed({1'b0, v});
        mul_b = $signed({2'b00, bct_pkg::RecipThree});
        l_d[s_q] = (bsum > 33'(bct_pkg::BasisOne)) ? bct_pkg::BasisOne : bsum[30:0];
        if (s_q == dege_q) begin
          if (ord_q == k_q) begin
            s_d     = 2'd0;
            state_d = S_RD;
          end else begin
            ord_d   = ord_q + 3'd1;
            s_d     = dege_q - ord_q[1:0];
            state_d = S_DMUL;
          end
        end else begin
          s_d     = s_q + 2'd1;
          state_d = S_DMUL;
        end
      end

      S_RD: begin
        ram_re  = 1'b1;
        state_d = S_MX;
      end

      S_MX: begin
        mul_a   = $signed({rd_x[31], rd_x});
        mul_b   = $signed({3'b000, lrd});
        prod_d  = mul_p;
        state_d = S_MY;
      end

      S_MY: begin
        accx_d  = accx_q + $signed(prod_q[65:0]);
        mul_a   = $signed({rd_y[31], rd_y});
        mul_b   = $signed({3'b000, lrd});
        prod_d  = mul_p;
        state_d = S_AY;
      end

      S_AY: begin
        accy_d = accy_q + $signed(prod_q[65:0]);
        if (s_q == dege_q) begin
          state_d = S_OUT;
        end else begin
          s_d     = s_q + 2'd1;
          state_d = S_RD;
        end
      end

      // hand the word over, advance or restart the walk
      S_OUT: begin
        if (!out_valid_q || smp_o.ready) begin
          out_word_d.out_x          = sat_coord(accx_q);
          out_word_d.out_y          = sat_coord(accy_q);
          out_word_d.last_sample    = last_q;
          out_word_d.too_few_points = few_q;
          out_valid_d               = 1'b1;
          if (few_q || last_q) begin
            cnt_d   = '0;
            accum_d = '0;
            step_d  = '0;
          end else begin
            cnt_d   = cnt_q + P1W'(1);
            accum_d = t_q + step_q;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // configuration writes: the user must issue them only while idle; the block does not enforce it
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bct_pkg::CfgDegree: begin
          deg_d   = cfg_data_i[1:0];
          cnt_d   = '0;
          accum_d = '0;
          step_d  = '0;
        end
        bct_pkg::CfgClosed: begin
          closed_d = cfg_data_i[0];
          cnt_d    = '0;
          accum_d  = '0;
          step_d   = '0;
        end
        bct_pkg::CfgSegments: begin
          spp_d   = cfg_data_i;
          cnt_d   = '0;
          accum_d = '0;
          step_d  = '0;
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      deg_q       <= 2'd3;
      closed_q    <= 1'b0;
      spp_q       <= 6'd8;
      pc_q        <= '0;
      cnt_q       <= '0;
      accum_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      deg_q       <= deg_d;
      closed_q    <= closed_d;
      spp_q       <= spp_d;
      pc_q        <= pc_d;
      cnt_q       <= cnt_d;
      accum_q     <= accum_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    dege_q     <= dege_d;
    npts_q     <= npts_d;
    p1_q       <= p1_d;
    t_q        <= t_d;
    last_q     <= last_d;
    few_q      <= few_d;
    b0_q       <= b0_d;
    ord_q      <= ord_d;
    s_q        <= s_d;
    l_q        <= l_d;
    prod_q     <= prod_d;
    d_q        <= d_d;
    accx_q     <= accx_d;
    accy_q     <= accy_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    dcnt_q     <= dcnt_d;
  end

endmodule

[bench/bct_sample_checker.sv]
// Checker: watches the request and sample channels, predicts samples and compares them.
module bct_sample_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  bct_pkg::req_word_t req_data_i,
  input  logic               smp_valid_i,
  input  logic               smp_ready_i,
  input  bct_pkg::smp_word_t smp_data_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 sample_count_o
);

  localparam int unsigned MaxPts = bct_pkg::MaxPointsDef;
  localparam longint     POne   = 64'sd1 << bct_pkg::PFrac;
  localparam longint     BOne   = 64'sd1 << bct_pkg::BFrac;

  // Predictor state
  logic [1:0]  degree_q;
  logic        closed_q;
  logic [5:0]  segs_q;
  logic signed [31:0] pts_x [MaxPts];
  logic signed [31:0] pts_y [MaxPts];
  int unsigned n_pts;
  int unsigned walk_idx;
  logic [31:0] t_accum;
  logic [31:0] t_step;
  longint      basis [MaxPts + 8];
  bct_pkg::smp_word_t expected_q [$];

  function automatic longint knot(int unsigned i, int unsigned np, int unsigned k, bit cl);
    if (cl) return longint'(i) - 1;
    if (i <= k) return 0;
    if (i <= np + 1) return longint'(i - k);
    return longint'(np + 1 - k);
  endfunction

  function automatic logic [31:0] sat_q12(longint acc);
    longint q;
    q = acc / BOne;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic restart_walk();
    walk_idx = 0;
    t_accum  = '0;
    t_step   = '0;
  endtask

  // Work out the sample that one request produces
  task automatic predict_sample();
    bct_pkg::smp_word_t w;
    int unsigned deg, k, np, spp, p1, npc, idx;
    bit          cl, last;
    longint      t, tend, sx, sy, tsum, rng, xi, xa, xb, xc, d, e, a, b;
    w = '0;
    deg = degree_q;
    if (deg == 0) deg = 1;
    k = deg + 1;
    if (n_pts < k) begin
      w.too_few_points = 1'b1;
      expected_q.push_back(w);
      restart_walk();
      return;
    end
    cl  = closed_q;
    np  = n_pts + (cl ? deg : 0);
    spp = segs_q;
    if (spp == 0) spp = 1;
    if (spp > 32) spp = 32;
    p1   = spp * np;
    npc  = np + k;
    tend = knot(npc, np, k, cl) * POne;
    if (walk_idx == 0) begin
      rng     = cl ? longint'(n_pts) : longint'(n_pts - deg);
      t_accum = cl ? 32'((k - 1) * POne) : '0;
      t_step  = 32'((rng * POne) / longint'(p1 - 1));
    end
    last = walk_idx >= p1 - 1;
    t = longint'(t_accum);
    if (t >= tend || tend - t <= bct_pkg::SnapUlps || (!cl && last)) t = tend;
    for (int unsigned i = 1; i + 1 <= npc; i++) begin
      a = knot(i, np, k, cl) * POne;
      b = knot(i + 1, np, k, cl) * POne;
      basis[i] = (t >= a && t < b) ? BOne : 0;
    end
    // Cox-de Boor recursion, terms truncated and clamped
    for (int unsigned o = 2; o <= k; o++) begin
      for (int unsigned i = 1; i + o <= npc; i++) begin
        xi = knot(i, np, k, cl);
        xa = knot(i + o - 1, np, k, cl);
        xb = knot(i + 1, np, k, cl);
        xc = knot(i + o, np, k, cl);
        d = 0;
        e = 0;
        if (basis[i] != 0 && xa > xi) d = ((t - xi * POne) * basis[i]) / ((xa - xi) * POne);
        if (basis[i + 1] != 0 && xc > xb)
          e = ((xc * POne - t) * basis[i + 1]) / ((xc - xb) * POne);
        basis[i] = d + e;
        if (basis[i] < 0) basis[i] = 0;
        if (basis[i] > BOne) basis[i] = BOne;
      end
    end
    if (t == tend) basis[np] = BOne;
    sx = 0;
    sy = 0;
    tsum = 0;
    for (int unsigned i = 1; i <= np; i++) begin
      idx = i - 1;
      if (idx >= n_pts) idx -= n_pts;
      tsum += basis[i];
      sx += basis[i] * longint'(pts_x[idx]);
      sy += basis[i] * longint'(pts_y[idx]);
    end
    if (tsum == 0) begin
      sx = 0;
      sy = 0;
    end
    w.out_x = sat_q12(sx);
    w.out_y = sat_q12(sy);
    w.last_sample = last;
    expected_q.push_back(w);
    if (last) restart_walk();
    else begin
      walk_idx++;
      t_accum = 32'(t + longint'(t_step));
    end
  endtask

  // Track configuration and requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q = 2'd3;
      closed_q = 1'b0;
      segs_q   = 6'd8;
      n_pts    = 0;
      restart_walk();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bct_pkg::CfgDegree:   degree_q = cfg_data_i[1:0];
          bct_pkg::CfgClosed:   closed_q = cfg_data_i[0];
          bct_pkg::CfgSegments: segs_q   = cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i inside {bct_pkg::CfgDegree, bct_pkg::CfgClosed, bct_pkg::CfgSegments})
          restart_walk();
      end
      if (req_valid_i && req_ready_i) begin
        case (req_data_i.op)
          bct_pkg::OP_CLEAR: begin
            n_pts = 0;
            restart_walk();
          end
          bct_pkg::OP_APPEND: begin
            if (n_pts < MaxPts) begin
              pts_x[n_pts] = req_data_i.in_x;
              pts_y[n_pts] = req_data_i.in_y;
              n_pts++;
            end
            restart_walk();
          end
          bct_pkg::OP_SAMPLE: predict_sample();
          default: ;
        endcase
      end
    end
  end

  // Compare accepted samples with the oldest expectation
  initial fail_count_o = 0;
  initial sample_count_o = 0;
  always @(posedge clk_i) begin
    bct_pkg::smp_word_t exp_w;
    if (rst_ni && smp_valid_i && smp_ready_i) begin
      sample_count_o <= sample_count_o + 1;
      if (expected_q.size() == 0) begin
        if (fail_count_o < 10) $display("unexpected sample word %h", smp_data_i);
        fail_count_o <= fail_count_o + 1;
      end else begin
        exp_w = expected_q.pop_front();
        if (exp_w !== smp_data_i) begin
          if (fail_count_o < 10)
            $display("sample mismatch: exp x=%h y=%h l=%b f=%b got x=%h y=%h l=%b f=%b",
                     exp_w.out_x, exp_w.out_y, exp_w.last_sample, exp_w.too_few_points,
                     smp_data_i.out_x, smp_data_i.out_y, smp_data_i.last_sample,
                     smp_data_i.too_few_points);
          fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

  assign pending_o = expected_q.size();

endmodule

[bench/bspline_curve_tessellator_tb.sv]
// Testbench top: drives requests, configuration and sample back-pressure, gives the verdict.
module bspline_curve_tessellator_tb;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = bct_pkg::CfgDegree;
  logic [5:0] cfg_data_i = '0;
  logic       hold_off = 1'b0;
  logic       calm = 1'b0;
  int         fail_count, pending, sample_count;
  int         idle_cycles = 0;
  int         sample_goal = 1120;

  bct_chan_if #(.word_t(bct_pkg::req_word_t)) req_if ();
  bct_chan_if #(.word_t(bct_pkg::smp_word_t)) smp_if ();

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    smp_if.ready = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bspline_curve_tessellator u_dut (
    .clk_i, .rst_ni, .req_i(req_if.sink), .smp_o(smp_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  bct_sample_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i(req_if.valid), .req_ready_i(req_if.ready), .req_data_i(req_if.data),
    .smp_valid_i(smp_if.valid), .smp_ready_i(smp_if.ready), .smp_data_i(smp_if.data),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .sample_count_o(sample_count)
  );

  // Sample receiver: random stalls, calm stretches, and one long hold-off
  always @(posedge clk_i) begin
    if (hold_off) smp_if.ready <= 1'b0;
    else smp_if.ready <= calm || ($urandom_range(99) >= 32);
  end

  initial begin
    wait (rst_ni);
    repeat (900) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (smp_if.valid && smp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("[bspline_curve_tessellator] ERROR");
      $finish;
    end
  end

  task automatic send_word(bct_pkg::op_e op, logic [31:0] x, logic [31:0] y);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid <= 1'b1;
    req_if.data  <= '{op: op, in_x: x, in_y: y};
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic go_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  // Load a random point set, then walk it with occasional noise
  task automatic run_curve(int unsigned npts, int unsigned nsamp);
    send_word(bct_pkg::OP_CLEAR, rand_coord(), rand_coord());
    repeat (npts) send_word(bct_pkg::OP_APPEND, rand_coord(), rand_coord());
    repeat (nsamp) begin
      case ($urandom_range(39))
        0: send_word(bct_pkg::OP_NONE, $urandom(), $urandom());
        1: send_word(bct_pkg::OP_APPEND, rand_coord(), rand_coord());
        2: send_word(bct_pkg::OP_CLEAR, $urandom(), $urandom());
        default: send_word(bct_pkg::OP_SAMPLE, $urandom(), $urandom());
      endcase
    end
  endtask

  initial begin
    int unsigned n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: too few points, extremes, snap at the end knot, full store
    send_word(bct_pkg::OP_SAMPLE, '0, '0);
    send_word(bct_pkg::OP_APPEND, 32'h7fff_ffff, 32'h8000_0000);
    send_word(bct_pkg::OP_APPEND, 32'h8000_0000, 32'h7fff_ffff);
    send_word(bct_pkg::OP_SAMPLE, '0, '0);
    send_word(bct_pkg::OP_APPEND, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(bct_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000);
    repeat (6) send_word(bct_pkg::OP_SAMPLE, '1, '1);
    send_word(bct_pkg::OP_NONE, '1, '1);
    send_word(bct_pkg::OP_SAMPLE, '0, '0);
    go_idle();
    write_reg(bct_pkg::CfgDegree, 6'd0);
    write_reg(bct_pkg::CfgSegments, 6'd0);
    run_curve(2, 5);
    go_idle();
    write_reg(bct_pkg::CfgDegree, 6'd3);
    write_reg(bct_pkg::CfgClosed, 6'd1);
    write_reg(bct_pkg::CfgSegments, 6'd63);
    send_word(bct_pkg::OP_CLEAR, '0, '0);
    repeat (66) send_word(bct_pkg::OP_APPEND, rand_coord(), rand_coord());
    send_word(bct_pkg::OP_SAMPLE, '0, '0);
    go_idle();

    // Random phases over the register settings
    while (sample_count < sample_goal) begin
      write_reg(bct_pkg::CfgDegree, 6'($urandom_range(3)));
      write_reg(bct_pkg::CfgClosed, 6'($urandom()));
      write_reg(bct_pkg::CfgSegments,
                ($urandom_range(3) == 0) ? 6'($urandom()) : 6'($urandom_range(1, 4)));
      calm = ($urandom_range(5) == 0);
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      if ($urandom_range(19) == 0) n = 64;
      run_curve(n, $urandom_range(20, 60));
      calm = 1'b0;
      go_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("[bspline_curve_tessellator] OK");
    end else begin
      $display("[bspline_curve_tessellator] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/bct_pkg.sv
hdl/bct_chan_if.sv
hdl/bct_ram.sv
hdl/bspline_curve_tessellator.sv
bench/bct_sample_checker.sv
bench/bspline_curve_tessellator_tb.sv
